/* rtl/lfcs_pkg.sv */
// Package for the line field and character selector.
// Holds the item types, configuration register indexes and shared constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lfcs_pkg;

  localparam int POS_W       = 10;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [POS_W-1:0] POS_MAX     = 10'd1023;
  localparam logic [7:0]       NEWLINE     = 8'h0A;
  localparam logic [7:0]       NUL_BYTE    = 8'h00;
  localparam logic [7:0]       DELIM_RESET = 8'h09;

  localparam logic [CFG_INDEX_W-1:0] REG_SELECT_CHARACTERS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER         = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_A_LOW       = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_A_HIGH      = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_B_LOW       = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_B_HIGH      = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_C_LOW       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_C_HIGH      = 4'd7;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] packed_bytes;
    logic [3:0]  byte_count;
    logic        last;
  } out_item_t;

  // Fixed part of a command from the front to the back.
  typedef struct packed {
    logic       wr;
    logic [7:0] wr_byte;
    logic       lit_valid;
    logic [7:0] lit_byte;
    logic       newline;
  } cmd_ctl_t;

  function automatic logic range_hit(input logic [POS_W-1:0] pos,
                                     input logic [POS_W-1:0] lo,
                                     input logic [POS_W-1:0] hi);
    return (lo != '0) && (pos >= lo) && (pos <= hi);
  endfunction

endpackage

`default_nettype wire

/* rtl/lfcs_queue.sv */
// Short first-in first-out queue between the front and the back.
// Depth comes from lfcs_pkg; the entry width is a parameter.
`default_nettype none

module lfcs_queue
  import lfcs_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [PW:0]      count;

  assign full       = (count == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !head_valid |-> !pop)
    else $error("queue read while empty");
  a_count_pointers: assert property (@(posedge clk) disable iff (rst)
    (PW'(count) == PW'(wp - rp)))
    else $error("queue count disagrees with pointers");
`endif

endmodule

`default_nettype wire

/* rtl/lfcs_front.sv */
// Front of the selector: configuration registers, line state and selection.
// Turns each accepted byte into at most one command for the back; uses lfcs_pkg.
`default_nettype none

module lfcs_front
  import lfcs_pkg::*;
#(
  parameter int LINE_BYTES  = 512,
  parameter int RANGE_COUNT = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          in_valid,
  input  wire in_item_t                      in_data,
  output logic                               in_stall,
  input  wire logic                          q_full,
  output logic                               push,
  output cmd_ctl_t                           cmd_ctl,
  output logic [$clog2(LINE_BYTES)-1:0]      cmd_waddr,
  output logic [$clog2(LINE_BYTES)-1:0]      cmd_flush_len
);

  localparam int AW = $clog2(LINE_BYTES);
  localparam logic [AW-1:0] SPLIT_AT = AW'(LINE_BYTES - 1);

  logic             sel_chars;
  logic [7:0]       delim;
  logic [POS_W-1:0] rlo [RANGE_COUNT];
  logic [POS_W-1:0] rhi [RANGE_COUNT];

  logic [POS_W-1:0] pos;
  logic [AW-1:0]    lbc;
  logic [AW-1:0]    ffl;
  logic             dseen;
  logic             nothing_emitted;
  logic             line_open;
  logic             nul_seen;

  logic [POS_W-1:0] pos_next;
  logic [AW-1:0]    lbc_next;
  logic [AW-1:0]    ffl_next;
  logic             dseen_next;
  logic             nothing_emitted_next;
  logic             line_open_next;
  logic             nul_seen_next;

  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] pos_inc2;
  logic             sel_one;
  logic             sel_p1;
  logic             sel_p2;
  logic             accept;
  logic             has_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_chars <= 1'b0;
      delim     <= DELIM_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SELECT_CHARACTERS) begin
        sel_chars <= cfg_data[0];
      end
      if (cfg_index == REG_DELIMITER) begin
        delim <= cfg_data[7:0];
      end
    end
  end

  for (genvar g = 0; g < RANGE_COUNT; g++) begin : g_range
    localparam logic [CFG_INDEX_W-1:0] LO_IDX = REG_RANGE_A_LOW + CFG_INDEX_W'(2 * g);
    localparam logic [CFG_INDEX_W-1:0] HI_IDX = REG_RANGE_A_HIGH + CFG_INDEX_W'(2 * g);
    always_ff @(posedge clk) begin
      if (rst) begin
        rlo[g] <= (g == 0) ? POS_W'(1) : '0;
        rhi[g] <= (g == 0) ? POS_MAX : '0;
      end else if (cfg_valid) begin
        if (cfg_index == LO_IDX) begin
          rlo[g] <= cfg_data;
        end
        if (cfg_index == HI_IDX) begin
          rhi[g] <= cfg_data;
        end
      end
    end
  end

  assign pos_inc  = (pos == POS_MAX) ? pos : pos + POS_W'(1);
  assign pos_inc2 = (pos_inc == POS_MAX) ? pos_inc : pos_inc + POS_W'(1);

  always_comb begin
    sel_one = 1'b0;
    sel_p1  = 1'b0;
    sel_p2  = 1'b0;
    for (int i = 0; i < RANGE_COUNT; i++) begin
      sel_one = sel_one | range_hit(POS_W'(1), rlo[i], rhi[i]);
      sel_p1  = sel_p1 | range_hit(pos_inc, rlo[i], rhi[i]);
      sel_p2  = sel_p2 | range_hit(pos_inc2, rlo[i], rhi[i]);
    end
  end

  always_comb begin
    logic finish;
    logic ne;
    pos_next             = pos;
    lbc_next             = lbc;
    ffl_next             = ffl;
    dseen_next           = dseen;
    nothing_emitted_next = nothing_emitted;
    line_open_next       = line_open;
    nul_seen_next        = nul_seen;
    cmd_ctl              = '0;
    cmd_waddr            = '0;
    cmd_flush_len        = '0;
    finish               = 1'b0;
    ne                   = nothing_emitted;
    if (in_data.kind) begin
      finish = line_open;
    end else if (in_data.text_byte == NEWLINE) begin
      finish = 1'b1;
    end else begin
      line_open_next = 1'b1;
      lbc_next       = lbc + AW'(1);
      if (!nul_seen) begin
        if (in_data.text_byte == NUL_BYTE) begin
          nul_seen_next = 1'b1;
        end else if (sel_chars) begin
          pos_next = pos_inc;
          if (sel_p1) begin
            cmd_ctl.lit_valid = 1'b1;
            cmd_ctl.lit_byte  = in_data.text_byte;
          end
        end else if (in_data.text_byte == delim) begin
          if (!dseen && sel_one) begin
            cmd_flush_len = ffl;
            ne            = 1'b0;
          end
          dseen_next = 1'b1;
          pos_next   = pos_inc;
          if (sel_p2) begin
            if (!ne) begin
              cmd_ctl.lit_valid = 1'b1;
              cmd_ctl.lit_byte  = delim;
            end
            ne = 1'b0;
          end
          nothing_emitted_next = ne;
        end else if (!dseen) begin
          cmd_ctl.wr      = 1'b1;
          cmd_ctl.wr_byte = in_data.text_byte;
          cmd_waddr       = ffl;
          ffl_next        = ffl + AW'(1);
        end else if (sel_p1) begin
          cmd_ctl.lit_valid = 1'b1;
          cmd_ctl.lit_byte  = in_data.text_byte;
        end
      end
      if (lbc_next == SPLIT_AT) begin
        finish = 1'b1;
      end
    end
    if (finish) begin
      if (!sel_chars && !dseen_next) begin
        cmd_flush_len = ffl_next;
      end
      cmd_ctl.newline      = 1'b1;
      pos_next             = '0;
      lbc_next             = '0;
      ffl_next             = '0;
      dseen_next           = 1'b0;
      nothing_emitted_next = 1'b1;
      line_open_next       = 1'b0;
      nul_seen_next        = 1'b0;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign has_cmd  = cmd_ctl.wr || cmd_ctl.lit_valid || cmd_ctl.newline || (cmd_flush_len != '0);
  assign push     = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      lbc             <= '0;
      ffl             <= '0;
      dseen           <= 1'b0;
      nothing_emitted <= 1'b1;
      line_open       <= 1'b0;
      nul_seen        <= 1'b0;
    end else if (accept) begin
      pos             <= pos_next;
      lbc             <= lbc_next;
      ffl             <= ffl_next;
      dseen           <= dseen_next;
      nothing_emitted <= nothing_emitted_next;
      line_open       <= line_open_next;
      nul_seen        <= nul_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_line_split: assert property (@(posedge clk) disable iff (rst) lbc < SPLIT_AT)
    else $error("line byte count passed the split point");
  a_first_field_fits: assert property (@(posedge clk) disable iff (rst) ffl <= lbc)
    else $error("first field longer than the line");
  a_closed_line_clear: assert property (@(posedge clk) disable iff (rst)
    !line_open |-> (lbc == '0 && ffl == '0 && pos == '0 && !dseen && !nul_seen))
    else $error("line state left behind after line end");
`endif

endmodule

`default_nettype wire

/* rtl/lfcs_back.sv */
// Back of the selector: first-field store, byte sequencer and eight-byte packer.
// Carries out commands from the queue and drives the result register; uses lfcs_pkg.
`default_nettype none

module lfcs_back
  import lfcs_pkg::*;
#(
  parameter int LINE_BYTES = 512
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_valid,
  input  wire cmd_ctl_t                  q_ctl,
  input  wire logic [$clog2(LINE_BYTES)-1:0] q_waddr,
  input  wire logic [$clog2(LINE_BYTES)-1:0] q_flush_len,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_item_t                      out_data
);

  localparam int AW = $clog2(LINE_BYTES);

  logic [7:0] store [LINE_BYTES];

  logic          adv;
  logic          cur_valid;
  logic [AW-1:0] cur_left;
  logic [AW-1:0] cur_addr;
  logic          cur_lit_v;
  logic [7:0]    cur_lit;
  logic          cur_nl;

  logic          h_present;
  logic [AW-1:0] h_left;
  logic [AW-1:0] h_addr;
  logic          h_lit_v;
  logic [7:0]    h_lit;
  logic          h_nl;

  logic          tok_valid;
  logic          tok_mem;
  logic [7:0]    tok_lit;
  logic          tok_end;
  logic [AW-1:0] rem_left;
  logic [AW-1:0] rem_addr;
  logic          rem_lit_v;
  logic          rem_nl;
  logic          rem_keep;
  logic          we;

  logic          s2_valid;
  logic          s2_mem;
  logic [7:0]    s2_lit;
  logic          s2_end;
  logic [7:0]    rdata;
  logic [7:0]    s2_byte;

  logic [63:0]   acc;
  logic [2:0]    acc_cnt;
  logic [63:0]   word;
  logic          emit;

  logic [63:0]   out_bytes;
  logic [3:0]    out_cnt;
  logic          out_last;

  assign adv       = !out_valid || !out_stall;
  assign h_present = cur_valid || q_valid;
  assign h_left    = cur_valid ? cur_left : q_flush_len;
  assign h_addr    = cur_valid ? cur_addr : '0;
  assign h_lit_v   = cur_valid ? cur_lit_v : q_ctl.lit_valid;
  assign h_lit     = cur_valid ? cur_lit : q_ctl.lit_byte;
  assign h_nl      = cur_valid ? cur_nl : q_ctl.newline;
  assign pop       = adv && !cur_valid && q_valid;
  assign we        = pop && q_ctl.wr;

  always_comb begin
    tok_valid = 1'b0;
    tok_mem   = 1'b0;
    tok_lit   = h_lit;
    tok_end   = 1'b0;
    rem_left  = h_left;
    rem_addr  = h_addr;
    rem_lit_v = h_lit_v;
    rem_nl    = h_nl;
    if (h_present) begin
      if (h_left != '0) begin
        tok_valid = 1'b1;
        tok_mem   = 1'b1;
        tok_end   = (h_left == AW'(1)) && !h_lit_v && !h_nl;
        rem_left  = h_left - AW'(1);
        rem_addr  = h_addr + AW'(1);
      end else if (h_lit_v) begin
        tok_valid = 1'b1;
        tok_end   = !h_nl;
        rem_lit_v = 1'b0;
      end else if (h_nl) begin
        tok_valid = 1'b1;
        tok_lit   = NEWLINE;
        tok_end   = 1'b1;
        rem_nl    = 1'b0;
      end
    end
    rem_keep = h_present && ((rem_left != '0) || rem_lit_v || rem_nl);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[q_waddr] <= q_ctl.wr_byte;
    end
    if (adv) begin
      rdata <= (we && (q_waddr == h_addr)) ? q_ctl.wr_byte : store[h_addr];
    end
  end

  assign s2_byte = s2_mem ? rdata : s2_lit;
  assign emit    = (acc_cnt == 3'd7) || s2_end;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (3'(j) < acc_cnt) begin
        word[j*8 +: 8] = acc[j*8 +: 8];
      end else if (3'(j) == acc_cnt) begin
        word[j*8 +: 8] = s2_byte;
      end else begin
        word[j*8 +: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc_cnt   <= '0;
    end else if (adv) begin
      cur_valid <= rem_keep;
      s2_valid  <= tok_valid;
      if (s2_valid) begin
        out_valid <= emit;
        acc_cnt   <= emit ? 3'd0 : acc_cnt + 3'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_left  <= rem_left;
      cur_addr  <= rem_addr;
      cur_lit_v <= rem_lit_v;
      cur_lit   <= h_lit;
      cur_nl    <= rem_nl;
      s2_mem    <= tok_mem;
      s2_lit    <= tok_lit;
      s2_end    <= tok_end;
      acc       <= word;
      out_bytes <= word;
      out_cnt   <= {1'b0, acc_cnt} + 4'd1;
      out_last  <= s2_end;
    end
  end

  assign out_data.packed_bytes = out_bytes;
  assign out_data.byte_count   = out_cnt;
  assign out_data.last         = out_last;

endmodule

`default_nettype wire

/* rtl/line_field_char_selector.sv */
// Line field and character selector, top level: configuration port, front,
// command queue and back. Depends on lfcs_pkg, lfcs_front, lfcs_queue and lfcs_back.
//
// The block takes one text byte per cycle while in_stall is low and returns the
// selected part of each line as results of up to eight bytes, marking the last
// result of each input byte. When a delimiter or the end of a line releases the
// buffered first field, the back reads it from the first-field store one byte per
// cycle while the output is not stalled; the four-entry command queue keeps taking
// input during that read until it fills. Results leave at most one per cycle from
// the output register. Configuration is written through its own port, which is
// always ready; the user must write it only while the block is idle, as the block
// itself does not enforce this.
`default_nettype none

module line_field_char_selector
  import lfcs_pkg::*;
#(
  parameter int LINE_BYTES  = 512,
  parameter int RANGE_COUNT = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(LINE_BYTES);
  localparam int QW = $bits(cmd_ctl_t) + 2 * AW;

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;
  cmd_ctl_t      f_ctl;
  logic [AW-1:0] f_waddr;
  logic [AW-1:0] f_len;
  logic [QW-1:0] q_head;
  cmd_ctl_t      b_ctl;
  logic [AW-1:0] b_waddr;
  logic [AW-1:0] b_len;

  assign cfg_ready = 1'b1;

  lfcs_front #(
    .LINE_BYTES  (LINE_BYTES),
    .RANGE_COUNT (RANGE_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .push          (push),
    .cmd_ctl       (f_ctl),
    .cmd_waddr     (f_waddr),
    .cmd_flush_len (f_len)
  );

  lfcs_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({f_ctl, f_waddr, f_len}),
    .pop        (pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign {b_ctl, b_waddr, b_len} = q_head;

  lfcs_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ctl       (b_ctl),
    .q_waddr     (b_waddr),
    .q_flush_len (b_len),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for line_field_char_selector: drives text bytes in bursts, stalls results on
// a pattern of its own and checks every result against a cycle-free model of the selection.
// Depends on lfcs_pkg and the line_field_char_selector RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfcs_pkg::*;

  localparam int LINE_BYTES    = 512;
  localparam int RANGE_COUNT   = 3;
  localparam int SETTLE_CYCLES = 640;
  localparam int RANDOM_ITEMS  = 380;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} check_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    logic                   is_end;
    check_t                 chk;
    logic [63:0]            word;
    logic [3:0]             cnt;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic       char_mode = 1'b0;
  logic [7:0] delim_cfg = DELIM_RESET;
  logic [9:0] range_lo [RANGE_COUNT] = '{10'd1, 10'd0, 10'd0};
  logic [9:0] range_hi [RANGE_COUNT] = '{10'd1023, 10'd0, 10'd0};

  // Line state of the selection model.
  int         pos_cnt = 0;
  int         line_len = 0;
  bit         delim_seen = 1'b0;
  bit         none_emitted = 1'b1;
  bit         line_open = 1'b0;
  bit         nul_hit = 1'b0;
  logic [7:0] first_field [LINE_BYTES];
  int         ff_len = 0;
  logic [7:0] line_out [$];

  out_item_t  expected_chunks [$];
  plan_row_t  plan [$];
  int         live_items = 0;
  int         burst_left = 0;
  int         mismatches = 0;
  int         results_seen = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  line_field_char_selector #(
    .LINE_BYTES (LINE_BYTES),
    .RANGE_COUNT(RANGE_COUNT)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("tb: mismatch at result %0d: %s", results_seen, what);
  endtask

  function automatic bit picked(input int pos);
    for (int i = 0; i < RANGE_COUNT; i++)
      if (range_lo[i] != 0 && pos >= range_lo[i] && pos <= range_hi[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int field_no();
    return (pos_cnt + 1 > POS_MAX) ? POS_MAX : pos_cnt + 1;
  endfunction

  function automatic void emit_first_field();
    for (int i = 0; i < ff_len; i++) line_out.push_back(first_field[i]);
  endfunction

  function automatic void end_line();
    if (!char_mode && !delim_seen) emit_first_field();
    line_out.push_back(NEWLINE);
    pos_cnt = 0;
    line_len = 0;
    delim_seen = 1'b0;
    none_emitted = 1'b1;
    line_open = 1'b0;
    nul_hit = 1'b0;
    ff_len = 0;
  endfunction

  // Applies one accepted request to the model and, if keep is set, queues the results it causes.
  task automatic select_bytes(input logic is_end, input logic [7:0] b, input bit keep);
    int        n;
    out_item_t chunk;
    line_out.delete();
    if (is_end) begin
      if (line_open) begin
        end_line();
        live_items++;
      end
    end else if (b == NEWLINE) begin
      end_line();
      live_items++;
    end else begin
      if (!nul_hit) live_items++;
      line_open = 1'b1;
      line_len++;
      if (!nul_hit) begin
        if (b == NUL_BYTE) begin
          nul_hit = 1'b1;
        end else if (char_mode) begin
          if (pos_cnt < POS_MAX) pos_cnt++;
          if (picked(pos_cnt)) line_out.push_back(b);
        end else if (b == delim_cfg) begin
          if (!delim_seen) begin
            delim_seen = 1'b1;
            if (picked(1)) begin
              emit_first_field();
              none_emitted = 1'b0;
            end
          end
          if (pos_cnt < POS_MAX) pos_cnt++;
          if (picked(field_no())) begin
            if (!none_emitted) line_out.push_back(delim_cfg);
            none_emitted = 1'b0;
          end
        end else if (!delim_seen) begin
          if (ff_len < LINE_BYTES) begin
            first_field[ff_len] = b;
            ff_len++;
          end
        end else if (picked(field_no())) begin
          line_out.push_back(b);
        end
      end
      if (line_len >= LINE_BYTES - 1) end_line();
    end
    if (keep) begin
      n = (line_out.size() + 7) / 8;
      for (int k = 0; k < n; k++) begin
        chunk = '0;
        for (int j = 0; j < 8 && k * 8 + j < line_out.size(); j++) begin
          chunk.packed_bytes[8*j +: 8] = line_out[k * 8 + j];
          chunk.byte_count = chunk.byte_count + 4'd1;
        end
        chunk.last = (k == n - 1);
        expected_chunks.push_back(chunk);
      end
    end
  endtask

  task automatic offer(input logic is_end, input logic [7:0] b, input bit keep);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= {is_end, b};
    do @(posedge clk); while (in_stall);
    select_bytes(is_end, b, keep);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SELECT_CHARACTERS: char_mode = val[0];
      REG_DELIMITER:         delim_cfg = val[7:0];
      REG_RANGE_A_LOW:       range_lo[0] = val;
      REG_RANGE_A_HIGH:      range_hi[0] = val;
      REG_RANGE_B_LOW:       range_lo[1] = val;
      REG_RANGE_B_HIGH:      range_hi[1] = val;
      REG_RANGE_C_LOW:       range_lo[2] = val;
      REG_RANGE_C_HIGH:      range_hi[2] = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every result is in, then long enough for a first-field read to finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_pos();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return POS_MAX;
      2:       return $urandom_range(0, 1023);
      3:       return 1;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic shuffle_settings();
    logic [7:0] d;
    case ($urandom_range(0, 7))
      0:       d = DELIM_RESET;
      1:       d = 8'h2C;
      2:       d = 8'h3A;
      3:       d = NUL_BYTE;
      4:       d = 8'hFF;
      5:       d = 8'h20;
      default: d = 8'($urandom_range(0, 255));
    endcase
    write_reg(REG_SELECT_CHARACTERS, 10'($urandom_range(0, 1)));
    write_reg(REG_DELIMITER, {2'b00, d});
    write_reg(REG_RANGE_A_LOW, 10'(pick_pos()));
    write_reg(REG_RANGE_A_HIGH, 10'(pick_pos()));
    write_reg(REG_RANGE_B_LOW, 10'(pick_pos()));
    write_reg(REG_RANGE_B_HIGH, 10'(pick_pos()));
    write_reg(REG_RANGE_C_LOW, 10'(pick_pos()));
    write_reg(REG_RANGE_C_HIGH, 10'(pick_pos()));
  endtask

  task automatic send_line();
    int         len;
    int         r;
    logic [7:0] b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 12);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 20) b = delim_cfg;
      else if (r < 23) b = NUL_BYTE;
      else if (r < 30) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(8'h61, 8'h7A));
      offer(1'b0, b, 1'b1);
    end
    r = $urandom_range(0, 19);
    if (r < 14) begin
      offer(1'b0, NEWLINE, 1'b1);
    end else if (r < 17) begin
      offer(1'b1, 8'($urandom_range(0, 255)), 1'b1);
      if (r == 16) offer(1'b1, 8'($urandom_range(0, 255)), 1'b1);
    end
    // Otherwise the line is left open, so the next settings apply to the rest of it.
  endtask

  function automatic void add_item(input logic is_end, input logic [7:0] b, input check_t chk,
                                   input logic [63:0] word, input logic [3:0] cnt);
    plan_row_t r;
    r = '{is_cfg: 1'b0, idx: '0, val: {2'b00, b}, is_end: is_end, chk: chk,
          word: word, cnt: cnt};
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] val);
    plan_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, val: val, is_end: 1'b0, chk: CHK_NONE, word: '0, cnt: '0};
    plan.push_back(r);
  endfunction

  always @(posedge clk) begin : stall_pattern
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      2:       out_stall <= (stall_left % 4 == 0);
      default: out_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chunks.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = expected_chunks.pop_front();
        if (out_data.packed_bytes !== want.packed_bytes)
          note_mismatch($sformatf("packed_bytes %h, want %h",
                                  out_data.packed_bytes, want.packed_bytes));
        if (out_data.byte_count !== want.byte_count)
          note_mismatch($sformatf("byte_count %0d, want %0d",
                                  out_data.byte_count, want.byte_count));
        if (out_data.last !== want.last)
          note_mismatch($sformatf("last %b, want %b", out_data.last, want.last));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: timed out with %0d results outstanding", expected_chunks.size());
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    out_item_t typed;
    int        goal;
    int        phase_goal;

    // Field mode after reset: tab delimiter, all fields selected.
    add_item(1'b0, 8'h61, CHK_NONE, '0, 4'd0);
    add_item(1'b0, 8'hFF, CHK_NONE, '0, 4'd0);
    add_item(1'b0, 8'h09, CHK_ONE, 64'h09FF61, 4'd3);
    add_item(1'b0, NUL_BYTE, CHK_NONE, '0, 4'd0);
    add_item(1'b0, 8'h62, CHK_NONE, '0, 4'd0);
    add_item(1'b0, NEWLINE, CHK_ONE, 64'h0A, 4'd1);
    add_item(1'b1, 8'hFF, CHK_NONE, '0, 4'd0);
    add_item(1'b0, 8'h78, CHK_NONE, '0, 4'd0);
    add_item(1'b1, 8'h00, CHK_ONE, 64'h0A78, 4'd2);
    // Character mode with a narrow range, a range at the top and an inverted one.
    add_cfg(REG_SELECT_CHARACTERS, 10'd1);
    add_cfg(REG_RANGE_A_LOW, 10'd2);
    add_cfg(REG_RANGE_A_HIGH, 10'd3);
    add_cfg(REG_RANGE_B_LOW, 10'd1023);
    add_cfg(REG_RANGE_B_HIGH, 10'd1023);
    add_cfg(REG_RANGE_C_LOW, 10'd5);
    add_cfg(REG_RANGE_C_HIGH, 10'd4);
    add_item(1'b0, 8'h70, CHK_NONE, '0, 4'd0);
    add_item(1'b0, 8'h71, CHK_ONE, 64'h71, 4'd1);
    add_item(1'b0, 8'h72, CHK_ONE, 64'h72, 4'd1);
    add_item(1'b0, 8'h73, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, 8'h74, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, NEWLINE, CHK_ONE, 64'h0A, 4'd1);
    // A NUL delimiter never splits a line.
    add_cfg(REG_SELECT_CHARACTERS, 10'd0);
    add_cfg(REG_DELIMITER, 10'd0);
    add_cfg(REG_RANGE_A_LOW, 10'd1);
    add_cfg(REG_RANGE_A_HIGH, 10'd1);
    add_item(1'b0, 8'h65, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, NUL_BYTE, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, 8'h66, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, NEWLINE, CHK_PREDICT, '0, 4'd0);
    // Second field only, with the top delimiter value.
    add_cfg(REG_DELIMITER, 10'd255);
    add_cfg(REG_RANGE_A_LOW, 10'd2);
    add_cfg(REG_RANGE_A_HIGH, 10'd2);
    add_cfg(REG_RANGE_B_LOW, 10'd0);
    add_cfg(REG_RANGE_C_LOW, 10'd0);
    add_item(1'b0, 8'h67, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, 8'hFF, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, 8'h68, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, 8'hFF, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, 8'h69, CHK_PREDICT, '0, 4'd0);
    add_item(1'b0, NEWLINE, CHK_PREDICT, '0, 4'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        offer(plan[i].is_end, plan[i].val[7:0], plan[i].chk == CHK_PREDICT);
        if (plan[i].chk == CHK_ONE) begin
          typed = {plan[i].word, plan[i].cnt, 1'b1};
          expected_chunks.push_back(typed);
        end
      end
    end

    // One line long enough to be split, with its whole first field released at once.
    settle();
    write_reg(REG_SELECT_CHARACTERS, 10'd0);
    write_reg(REG_DELIMITER, {2'b00, DELIM_RESET});
    write_reg(REG_RANGE_A_LOW, 10'd1);
    write_reg(REG_RANGE_A_HIGH, POS_MAX);
    write_reg(REG_RANGE_B_LOW, 10'd0);
    write_reg(REG_RANGE_C_LOW, 10'd0);
    repeat (LINE_BYTES + 3) offer(1'b0, 8'($urandom_range(8'h61, 8'h7A)), 1'b1);
    offer(1'b0, NEWLINE, 1'b1);

    goal = live_items + RANDOM_ITEMS;
    while (live_items < goal) begin
      settle();
      shuffle_settings();
      phase_goal = live_items + $urandom_range(20, 45);
      while (live_items < phase_goal) send_line();
    end

    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lfcs_pkg.sv
rtl/lfcs_queue.sv
rtl/lfcs_front.sv
rtl/lfcs_back.sv
rtl/line_field_char_selector.sv
bench/tb.sv
